>>> sv/atl_pkg.sv
// shared types, constants and character helpers for the assembler token lexer
`timescale 1ns / 1ps
package atl_pkg;

  typedef enum logic [4:0] {
    M_IDLE, M_LCOM, M_BLK, M_BLKSTAR, M_SLASH, M_OP, M_NAME, M_NAMEWS,
    M_ZERO, M_HEX, M_BIN, M_DEC, M_FRAC, M_EXP0, M_EXPSGN, M_EXPDIG,
    M_CHR, M_CHRESC, M_STR, M_STRESC
  } lex_mode_t;

  typedef enum logic [2:0] {PH_WAIT, PH_PROC, PH_RUNPRE, PH_RUN, PH_END} phase_t;
  typedef enum logic [1:0] {AFT_WAIT, AFT_PROC, AFT_END} after_t;
  typedef enum logic [2:0] {
    ACC_HOLD, ACC_ZERO, ACC_DIGIT, ACC_HEX, ACC_BIN, ACC_DEC, ACC_CHR, ACC_TCNT
  } acc_op_t;
  typedef enum logic [2:0] {
    TXT_HOLD, TXT_START, TXT_CLEAR, TXT_ADD, TXT_OVF, TXT_FROMACC, TXT_QMARK
  } txt_op_t;
  typedef enum logic [2:0] {
    VAL_ZERO, VAL_ACC, VAL_BYTE, VAL_LOOK, VAL_SLASH, VAL_RUN
  } val_sel_t;
  typedef enum logic [1:0] {ESC_CHAR, ESC_NONE, ESC_BAD} esc_class_t;

  localparam logic [3:0] KIND_END    = 4'd0;
  localparam logic [3:0] KIND_NAME   = 4'd1;
  localparam logic [3:0] KIND_LABEL  = 4'd2;
  localparam logic [3:0] KIND_NUMBER = 4'd3;
  localparam logic [3:0] KIND_FLOAT  = 4'd4;
  localparam logic [3:0] KIND_CHAR   = 4'd5;
  localparam logic [3:0] KIND_STRING = 4'd6;
  localparam logic [3:0] KIND_SINGLE = 4'd7;
  localparam logic [3:0] KIND_SHL    = 4'd8;
  localparam logic [3:0] KIND_SHR    = 4'd9;
  localparam logic [3:0] KIND_INC    = 4'd10;
  localparam logic [3:0] KIND_DEC    = 4'd11;
  localparam logic [3:0] KIND_BARBAR = 4'd12;
  localparam logic [3:0] KIND_DIAG   = 4'd13;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_EOF_COM   = 4'd1;
  localparam logic [3:0] ERR_EOF_CHR   = 4'd2;
  localparam logic [3:0] ERR_EOF_STR   = 4'd3;
  localparam logic [3:0] ERR_EMPTY_CHR = 4'd4;
  localparam logic [3:0] ERR_LONG_CHR  = 4'd5;
  localparam logic [3:0] ERR_EMPTY_STR = 4'd6;
  localparam logic [3:0] ERR_BAD_ESC   = 4'd7;
  localparam logic [3:0] ERR_CNTRL     = 4'd8;
  localparam logic [3:0] ERR_BAD_EXP   = 4'd9;
  localparam logic [3:0] ERR_TRUNC     = 4'd10;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_UB     = 8'h42;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  typedef struct packed {
    logic       load_in;
    acc_op_t    acc_op;
    logic       use_esc;
    txt_op_t    txt_op;
    logic       cc_zero;
    logic       cc_inc;
    logic       look_load;
    logic       line_inc;
    logic       sol_set;
    logic       sol_clear;
    logic       emit;
    logic [3:0] kind;
    val_sel_t   val_sel;
    logic       last;
    logic [3:0] err;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eof;
    logic       ti_en;
    logic       barbar_en;
    logic       sol;
    logic       cnt_eq_max;
    logic       cnt_ge_max;
    logic       cnt_zero;
    logic [2:0] cc;
    logic [7:0] look;
    logic       out_free;
  } dp_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_namech(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_DOT || c == CH_UNDER;
  endfunction

  function automatic logic is_cntrl(input logic [7:0] c);
    return c < CH_SPACE || c == CH_DEL;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (is_digit(c)) v = c[3:0];
    else v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic esc_class_t esc_class(input logic [7:0] c);
    esc_class_t r;
    unique case (c)
      8'h6e, 8'h72, 8'h61, 8'h62, 8'h66, 8'h74, 8'h76,
      CH_BSLASH, CH_QUOTE, CH_DQUOTE: r = ESC_CHAR;
      CH_ZERO: r = ESC_NONE;
      default: r = ESC_BAD;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] esc_val(input logic [7:0] c);
    logic [7:0] v;
    unique case (c)
      8'h6e: v = 8'd10;
      8'h72: v = 8'd13;
      8'h61: v = 8'd7;
      8'h62: v = 8'd8;
      8'h66: v = 8'd12;
      8'h74: v = 8'd9;
      8'h76: v = 8'd11;
      CH_BSLASH, CH_QUOTE, CH_DQUOTE: v = c;
      default: v = CH_QMARK;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] op_kind(input logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      CH_LT:    k = KIND_SHL;
      CH_GT:    k = KIND_SHR;
      CH_PLUS:  k = KIND_INC;
      CH_MINUS: k = KIND_DEC;
      default:  k = KIND_BARBAR;
    endcase
    return k;
  endfunction

endpackage

>>> sv/atl_datapath.sv
// lexer datapath: input hold, accumulators, text buffer, line count, result register
`timescale 1ns / 1ps
module atl_datapath #(
  parameter int MAX_TEXT  = 32,
  parameter int LINE_BITS = 16,
  parameter int AW        = $clog2(MAX_TEXT),
  parameter int CW        = $clog2(MAX_TEXT + 2)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           byte_in,
  input  logic                 end_of_input,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  atl_pkg::dp_cmd_t     cmd,
  input  logic [AW-1:0]        rd_addr,
  output atl_pkg::dp_stat_t    st,
  output logic [CW-1:0]        run_n,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [3:0]           token_kind,
  output logic [31:0]          token_value,
  output logic                 run_last,
  output logic [15:0]          line_number,
  output logic [3:0]           error_code
);

  localparam logic [CW-1:0] MAXC = CW'(MAX_TEXT);

  logic [7:0]           c;
  logic                 eof;
  logic                 ti_en;
  logic                 barbar_en;
  logic [31:0]          acc;
  logic [CW-1:0]        text_count;
  logic [2:0]           cc;
  logic [7:0]           look;
  logic [LINE_BITS-1:0] line_count;
  logic [LINE_BITS-1:0] line_count_next;
  logic                 sol;
  logic [7:0]           mem [MAX_TEXT];
  logic [7:0]           rdata;
  logic [7:0]           cdata;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [7:0]           wdata;
  logic [31:0]          lwide;
  logic [31:0]          val;

  assign cdata = cmd.use_esc ? atl_pkg::esc_val(c) : c;

  always_comb begin
    line_count_next = line_count;
    if (cmd.line_inc && line_count != {LINE_BITS{1'b1}}) begin
      line_count_next = line_count + LINE_BITS'(1);
    end
    lwide = 32'(line_count_next);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wdata   = cdata;
    case (cmd.txt_op)
      atl_pkg::TXT_START: wr_en = 1'b1;
      atl_pkg::TXT_QMARK: begin
        wr_en = 1'b1;
        wdata = atl_pkg::CH_QMARK;
      end
      atl_pkg::TXT_ADD: begin
        wr_en   = text_count < MAXC;
        wr_addr = text_count[AW-1:0];
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      c   <= byte_in;
      eof <= end_of_input;
    end
    if (cmd.look_load) begin
      look <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ti_en      <= 1'b0;
      barbar_en  <= 1'b0;
      acc        <= '0;
      text_count <= '0;
      cc         <= '0;
      line_count <= LINE_BITS'(1);
      sol        <= 1'b1;
    end else begin
      if (cfg_valid && cfg_index == 8'd0) ti_en <= cfg_data[0];
      if (cfg_valid && cfg_index == 8'd1) barbar_en <= cfg_data[0];
      line_count <= line_count_next;
      if (cmd.sol_set) sol <= 1'b1;
      else if (cmd.sol_clear) sol <= 1'b0;
      if (cmd.cc_zero) cc <= '0;
      else if (cmd.cc_inc && cc < 3'd5) cc <= cc + 3'd1;
      case (cmd.acc_op)
        atl_pkg::ACC_ZERO:  acc <= '0;
        atl_pkg::ACC_DIGIT: acc <= 32'(c[3:0]);
        atl_pkg::ACC_HEX:   acc <= {acc[27:0], atl_pkg::hex_val(c)};
        atl_pkg::ACC_BIN:   acc <= {acc[30:0], c[0]};
        atl_pkg::ACC_DEC:   acc <= (acc << 3) + (acc << 1) + 32'(c[3:0]);
        atl_pkg::ACC_CHR:   acc <= {acc[23:0], cdata};
        atl_pkg::ACC_TCNT:  acc <= 32'(text_count);
        default:            acc <= acc;
      endcase
      case (cmd.txt_op)
        atl_pkg::TXT_START, atl_pkg::TXT_QMARK: text_count <= CW'(1);
        atl_pkg::TXT_CLEAR: text_count <= '0;
        atl_pkg::TXT_ADD: begin
          if (text_count <= MAXC) text_count <= text_count + CW'(1);
        end
        atl_pkg::TXT_OVF: text_count <= MAXC + CW'(1);
        atl_pkg::TXT_FROMACC: begin
          if (acc > 32'(MAX_TEXT)) text_count <= MAXC + CW'(1);
          else text_count <= acc[CW-1:0];
        end
        default: text_count <= text_count;
      endcase
    end
  end

  always_comb begin
    case (cmd.val_sel)
      atl_pkg::VAL_ACC:   val = acc;
      atl_pkg::VAL_BYTE:  val = 32'(c);
      atl_pkg::VAL_LOOK:  val = 32'(look);
      atl_pkg::VAL_SLASH: val = 32'(atl_pkg::CH_SLASH);
      atl_pkg::VAL_RUN:   val = 32'(rdata);
      default:            val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      token_kind  <= cmd.kind;
      token_value <= val;
      run_last    <= cmd.last;
      error_code  <= cmd.err;
      line_number <= (lwide > 32'd65535) ? 16'hffff : lwide[15:0];
    end
  end

  assign run_n = (text_count > MAXC) ? MAXC : text_count;

  always_comb begin
    st.c          = c;
    st.eof        = eof;
    st.ti_en      = ti_en;
    st.barbar_en  = barbar_en;
    st.sol        = sol;
    st.cnt_eq_max = text_count == MAXC;
    st.cnt_ge_max = text_count >= MAXC;
    st.cnt_zero   = text_count == '0;
    st.cc         = cc;
    st.look       = look;
    st.out_free   = !out_valid || out_ready;
  end

endmodule

>>> sv/atl_controller.sv
// lexer controller: lexical mode and sequencing of results
`timescale 1ns / 1ps
module atl_controller #(
  parameter int MAX_TEXT = 32,
  parameter int AW       = $clog2(MAX_TEXT),
  parameter int CW       = $clog2(MAX_TEXT + 2)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  atl_pkg::dp_stat_t    st,
  input  logic [CW-1:0]        run_n,
  output atl_pkg::dp_cmd_t     cmd,
  output logic [AW-1:0]        rd_addr
);

  atl_pkg::lex_mode_t mode, mode_next;
  atl_pkg::phase_t    phase, phase_next;
  atl_pkg::after_t    run_after, run_after_next;
  logic               eof_seen, eof_seen_next;
  logic               diag_done, diag_done_next;
  logic [3:0]         run_kind, run_kind_next;
  logic [CW-1:0]      run_idx, run_idx_next;
  logic [7:0]         c;
  logic               run_is_last;

  function automatic atl_pkg::dp_cmd_t em(input atl_pkg::dp_cmd_t b, input logic [3:0] k,
                                          input atl_pkg::val_sel_t v, input logic [3:0] e);
    atl_pkg::dp_cmd_t r;
    r         = b;
    r.emit    = 1'b1;
    r.kind    = k;
    r.val_sel = v;
    r.last    = 1'b1;
    r.err     = e;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= atl_pkg::M_IDLE;
      phase     <= atl_pkg::PH_WAIT;
      run_after <= atl_pkg::AFT_WAIT;
      eof_seen  <= 1'b0;
      diag_done <= 1'b0;
      run_kind  <= '0;
      run_idx   <= '0;
    end else begin
      mode      <= mode_next;
      phase     <= phase_next;
      run_after <= run_after_next;
      eof_seen  <= eof_seen_next;
      diag_done <= diag_done_next;
      run_kind  <= run_kind_next;
      run_idx   <= run_idx_next;
    end
  end

  assign c           = st.c;
  assign run_is_last = (run_idx + CW'(1)) == run_n;
  assign in_ready    = phase == atl_pkg::PH_WAIT;

  always_comb begin
    cmd            = '0;
    mode_next      = mode;
    phase_next     = phase;
    run_after_next = run_after;
    eof_seen_next  = eof_seen;
    diag_done_next = diag_done;
    run_kind_next  = run_kind;
    run_idx_next   = run_idx;
    rd_addr        = run_idx[AW-1:0];
    unique case (phase)
      atl_pkg::PH_WAIT: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          phase_next  = atl_pkg::PH_PROC;
        end
      end
      atl_pkg::PH_RUNPRE: begin
        rd_addr    = '0;
        phase_next = atl_pkg::PH_RUN;
      end
      atl_pkg::PH_RUN: begin
        if (st.out_free) begin
          cmd      = em(cmd, run_kind, atl_pkg::VAL_RUN, atl_pkg::ERR_NONE);
          cmd.last = run_is_last;
          if (run_is_last) begin
            unique case (run_after)
              atl_pkg::AFT_END:  phase_next = atl_pkg::PH_END;
              atl_pkg::AFT_PROC: phase_next = atl_pkg::PH_PROC;
              default:           phase_next = atl_pkg::PH_WAIT;
            endcase
          end else begin
            run_idx_next = run_idx + CW'(1);
            rd_addr      = run_idx_next[AW-1:0];
          end
        end
      end
      atl_pkg::PH_END: begin
        if (st.out_free) begin
          cmd           = em(cmd, atl_pkg::KIND_END, atl_pkg::VAL_ZERO, atl_pkg::ERR_NONE);
          eof_seen_next = 1'b1;
          phase_next    = atl_pkg::PH_WAIT;
        end
      end
      atl_pkg::PH_PROC: begin
        if (st.out_free) begin
          if (eof_seen) begin
            cmd        = em(cmd, atl_pkg::KIND_END, atl_pkg::VAL_ZERO, atl_pkg::ERR_NONE);
            phase_next = atl_pkg::PH_WAIT;
          end else if (st.eof) begin
            mode_next      = atl_pkg::M_IDLE;
            phase_next     = atl_pkg::PH_END;
            run_idx_next   = '0;
            run_after_next = atl_pkg::AFT_END;
            unique case (mode)
              atl_pkg::M_BLK, atl_pkg::M_BLKSTAR:
                cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_EOF_COM);
              atl_pkg::M_CHR, atl_pkg::M_CHRESC:
                cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_EOF_CHR);
              atl_pkg::M_STR, atl_pkg::M_STRESC:
                cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_EOF_STR);
              atl_pkg::M_SLASH:
                cmd = em(cmd, atl_pkg::KIND_SINGLE, atl_pkg::VAL_SLASH, atl_pkg::ERR_NONE);
              atl_pkg::M_OP:
                cmd = em(cmd, atl_pkg::KIND_SINGLE, atl_pkg::VAL_LOOK, atl_pkg::ERR_NONE);
              atl_pkg::M_NAME, atl_pkg::M_NAMEWS: begin
                run_kind_next = atl_pkg::KIND_NAME;
                phase_next    = atl_pkg::PH_RUNPRE;
              end
              atl_pkg::M_ZERO, atl_pkg::M_HEX, atl_pkg::M_BIN, atl_pkg::M_DEC:
                cmd = em(cmd, atl_pkg::KIND_NUMBER, atl_pkg::VAL_ACC, atl_pkg::ERR_NONE);
              atl_pkg::M_FRAC, atl_pkg::M_EXPDIG: begin
                run_kind_next = atl_pkg::KIND_FLOAT;
                phase_next    = atl_pkg::PH_RUNPRE;
              end
              atl_pkg::M_EXP0, atl_pkg::M_EXPSGN: begin
                cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_BAD_EXP);
                cmd.txt_op    = atl_pkg::TXT_FROMACC;
                run_kind_next = atl_pkg::KIND_FLOAT;
                phase_next    = atl_pkg::PH_RUNPRE;
              end
              default: begin
                cmd = em(cmd, atl_pkg::KIND_END, atl_pkg::VAL_ZERO, atl_pkg::ERR_NONE);
                eof_seen_next = 1'b1;
                phase_next    = atl_pkg::PH_WAIT;
              end
            endcase
          end else begin
            run_idx_next = '0;
            unique case (mode)
              atl_pkg::M_LCOM: begin
                phase_next = atl_pkg::PH_WAIT;
                if (c == atl_pkg::CH_NL) begin
                  cmd.line_inc = 1'b1;
                  cmd.sol_set  = 1'b1;
                  mode_next    = atl_pkg::M_IDLE;
                end
              end
              atl_pkg::M_BLK: begin
                phase_next = atl_pkg::PH_WAIT;
                if (c == atl_pkg::CH_NL) cmd.line_inc = 1'b1;
                else if (c == atl_pkg::CH_STAR) mode_next = atl_pkg::M_BLKSTAR;
              end
              atl_pkg::M_BLKSTAR: begin
                phase_next = atl_pkg::PH_WAIT;
                if (c == atl_pkg::CH_SLASH) begin
                  mode_next = atl_pkg::M_IDLE;
                end else if (c != atl_pkg::CH_STAR) begin
                  cmd.line_inc = c == atl_pkg::CH_NL;
                  mode_next    = atl_pkg::M_BLK;
                end
              end
              atl_pkg::M_SLASH: begin
                if (c == atl_pkg::CH_SLASH) begin
                  mode_next  = atl_pkg::M_LCOM;
                  phase_next = atl_pkg::PH_WAIT;
                end else if (c == atl_pkg::CH_STAR) begin
                  mode_next  = atl_pkg::M_BLK;
                  phase_next = atl_pkg::PH_WAIT;
                end else begin
                  cmd = em(cmd, atl_pkg::KIND_SINGLE, atl_pkg::VAL_SLASH, atl_pkg::ERR_NONE);
                  mode_next = atl_pkg::M_IDLE;
                end
              end
              atl_pkg::M_OP: begin
                mode_next = atl_pkg::M_IDLE;
                if (c == st.look) begin
                  cmd = em(cmd, atl_pkg::op_kind(c), atl_pkg::VAL_BYTE, atl_pkg::ERR_NONE);
                  phase_next = atl_pkg::PH_WAIT;
                end else begin
                  cmd = em(cmd, atl_pkg::KIND_SINGLE, atl_pkg::VAL_LOOK, atl_pkg::ERR_NONE);
                end
              end
              atl_pkg::M_NAME, atl_pkg::M_NAMEWS: begin
                if (mode == atl_pkg::M_NAME && atl_pkg::is_namech(c)) begin
                  cmd.txt_op = atl_pkg::TXT_ADD;
                  if (st.cnt_eq_max)
                    cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_TRUNC);
                  phase_next = atl_pkg::PH_WAIT;
                end else if (atl_pkg::is_space(c)) begin
                  cmd.line_inc  = c == atl_pkg::CH_NL;
                  cmd.sol_set   = c == atl_pkg::CH_NL;
                  cmd.sol_clear = c != atl_pkg::CH_NL;
                  mode_next     = atl_pkg::M_NAMEWS;
                  phase_next    = atl_pkg::PH_WAIT;
                end else begin
                  mode_next  = atl_pkg::M_IDLE;
                  phase_next = atl_pkg::PH_RUNPRE;
                  if (c == atl_pkg::CH_COLON) begin
                    run_kind_next  = atl_pkg::KIND_LABEL;
                    run_after_next = atl_pkg::AFT_WAIT;
                  end else begin
                    run_kind_next  = atl_pkg::KIND_NAME;
                    run_after_next = atl_pkg::AFT_PROC;
                  end
                end
              end
              atl_pkg::M_ZERO: begin
                if (c == atl_pkg::CH_LX || c == atl_pkg::CH_UX) begin
                  cmd.acc_op = atl_pkg::ACC_ZERO;
                  mode_next  = atl_pkg::M_HEX;
                  phase_next = atl_pkg::PH_WAIT;
                end else if (c == atl_pkg::CH_LB || c == atl_pkg::CH_UB) begin
                  cmd.acc_op = atl_pkg::ACC_ZERO;
                  mode_next  = atl_pkg::M_BIN;
                  phase_next = atl_pkg::PH_WAIT;
                end else begin
                  mode_next = atl_pkg::M_DEC;
                end
              end
              atl_pkg::M_HEX: begin
                if (atl_pkg::is_hex(c)) begin
                  cmd.acc_op = atl_pkg::ACC_HEX;
                  phase_next = atl_pkg::PH_WAIT;
                end else begin
                  cmd = em(cmd, atl_pkg::KIND_NUMBER, atl_pkg::VAL_ACC, atl_pkg::ERR_NONE);
                  mode_next = atl_pkg::M_IDLE;
                end
              end
              atl_pkg::M_BIN: begin
                if (c == atl_pkg::CH_ZERO || c == atl_pkg::CH_ONE) begin
                  cmd.acc_op = atl_pkg::ACC_BIN;
                  phase_next = atl_pkg::PH_WAIT;
                end else begin
                  cmd = em(cmd, atl_pkg::KIND_NUMBER, atl_pkg::VAL_ACC, atl_pkg::ERR_NONE);
                  mode_next = atl_pkg::M_IDLE;
                end
              end
              atl_pkg::M_DEC: begin
                if (atl_pkg::is_digit(c)) begin
                  cmd.acc_op = atl_pkg::ACC_DEC;
                  cmd.txt_op = atl_pkg::TXT_ADD;
                  phase_next = atl_pkg::PH_WAIT;
                end else if (c == atl_pkg::CH_DOT) begin
                  if (st.cnt_ge_max) begin
                    cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_TRUNC);
                    cmd.txt_op = atl_pkg::TXT_OVF;
                  end else begin
                    cmd.txt_op = atl_pkg::TXT_ADD;
                  end
                  mode_next  = atl_pkg::M_FRAC;
                  phase_next = atl_pkg::PH_WAIT;
                end else begin
                  cmd = em(cmd, atl_pkg::KIND_NUMBER, atl_pkg::VAL_ACC, atl_pkg::ERR_NONE);
                  mode_next = atl_pkg::M_IDLE;
                end
              end
              atl_pkg::M_FRAC, atl_pkg::M_EXPDIG, atl_pkg::M_EXP0, atl_pkg::M_EXPSGN: begin
                if (atl_pkg::is_digit(c) ||
                    (mode == atl_pkg::M_FRAC && (c == atl_pkg::CH_LE || c == atl_pkg::CH_UE)) ||
                    (mode == atl_pkg::M_EXP0 &&
                     (c == atl_pkg::CH_PLUS || c == atl_pkg::CH_MINUS))) begin
                  cmd.txt_op = atl_pkg::TXT_ADD;
                  if (st.cnt_eq_max)
                    cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_TRUNC);
                  phase_next = atl_pkg::PH_WAIT;
                  if (mode == atl_pkg::M_FRAC && !atl_pkg::is_digit(c)) begin
                    cmd.acc_op = atl_pkg::ACC_TCNT;
                    mode_next  = atl_pkg::M_EXP0;
                  end else if (mode == atl_pkg::M_EXP0 && !atl_pkg::is_digit(c)) begin
                    mode_next = atl_pkg::M_EXPSGN;
                  end else if (mode != atl_pkg::M_FRAC) begin
                    mode_next = atl_pkg::M_EXPDIG;
                  end
                end else begin
                  if (mode == atl_pkg::M_EXP0 || mode == atl_pkg::M_EXPSGN) begin
                    cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_BAD_EXP);
                    cmd.txt_op = atl_pkg::TXT_FROMACC;
                  end
                  mode_next      = atl_pkg::M_IDLE;
                  run_kind_next  = atl_pkg::KIND_FLOAT;
                  run_after_next = atl_pkg::AFT_PROC;
                  phase_next     = atl_pkg::PH_RUNPRE;
                end
              end
              atl_pkg::M_CHR, atl_pkg::M_STR: begin
                phase_next = atl_pkg::PH_WAIT;
                if (mode == atl_pkg::M_CHR && c == atl_pkg::CH_QUOTE) begin
                  if (!diag_done && (st.cc == 3'd0 || st.cc > 3'd4)) begin
                    cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO,
                             (st.cc == 3'd0) ? atl_pkg::ERR_EMPTY_CHR : atl_pkg::ERR_LONG_CHR);
                    diag_done_next = 1'b1;
                    phase_next     = atl_pkg::PH_PROC;
                  end else begin
                    cmd = em(cmd, atl_pkg::KIND_CHAR, atl_pkg::VAL_ACC, atl_pkg::ERR_NONE);
                    diag_done_next = 1'b0;
                    mode_next      = atl_pkg::M_IDLE;
                  end
                end else if (mode == atl_pkg::M_STR && c == atl_pkg::CH_DQUOTE) begin
                  if (st.cnt_zero) begin
                    cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_EMPTY_STR);
                    cmd.txt_op = atl_pkg::TXT_QMARK;
                    phase_next = atl_pkg::PH_PROC;
                  end else begin
                    mode_next      = atl_pkg::M_IDLE;
                    run_kind_next  = atl_pkg::KIND_STRING;
                    run_after_next = atl_pkg::AFT_WAIT;
                    phase_next     = atl_pkg::PH_RUNPRE;
                  end
                end else if (c == atl_pkg::CH_BSLASH) begin
                  mode_next = (mode == atl_pkg::M_CHR) ? atl_pkg::M_CHRESC : atl_pkg::M_STRESC;
                end else if (atl_pkg::is_cntrl(c) && c != atl_pkg::CH_TAB) begin
                  cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_CNTRL);
                  cmd.line_inc = c == atl_pkg::CH_NL;
                end else if (mode == atl_pkg::M_CHR) begin
                  cmd.acc_op = atl_pkg::ACC_CHR;
                  cmd.cc_inc = 1'b1;
                end else begin
                  cmd.txt_op = atl_pkg::TXT_ADD;
                  if (st.cnt_eq_max)
                    cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_TRUNC);
                end
              end
              atl_pkg::M_CHRESC: begin
                phase_next   = atl_pkg::PH_WAIT;
                mode_next    = atl_pkg::M_CHR;
                cmd.line_inc = c == atl_pkg::CH_NL;
                cmd.use_esc  = 1'b1;
                if (atl_pkg::esc_class(c) != atl_pkg::ESC_NONE) begin
                  cmd.acc_op = atl_pkg::ACC_CHR;
                  cmd.cc_inc = 1'b1;
                end
                if (atl_pkg::esc_class(c) == atl_pkg::ESC_BAD)
                  cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_BAD_ESC);
              end
              atl_pkg::M_STRESC: begin
                cmd.use_esc = 1'b1;
                if (atl_pkg::esc_class(c) == atl_pkg::ESC_BAD && !diag_done) begin
                  cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_BAD_ESC);
                  cmd.line_inc   = c == atl_pkg::CH_NL;
                  diag_done_next = 1'b1;
                end else begin
                  diag_done_next = 1'b0;
                  mode_next      = atl_pkg::M_STR;
                  phase_next     = atl_pkg::PH_WAIT;
                  if (atl_pkg::esc_class(c) != atl_pkg::ESC_NONE) begin
                    cmd.txt_op = atl_pkg::TXT_ADD;
                    if (st.cnt_eq_max)
                      cmd = em(cmd, atl_pkg::KIND_DIAG, atl_pkg::VAL_ZERO, atl_pkg::ERR_TRUNC);
                  end
                end
              end
              default: begin
                mode_next  = atl_pkg::M_IDLE;
                phase_next = atl_pkg::PH_WAIT;
                if (atl_pkg::is_space(c)) begin
                  cmd.line_inc  = c == atl_pkg::CH_NL;
                  cmd.sol_set   = c == atl_pkg::CH_NL;
                  cmd.sol_clear = c != atl_pkg::CH_NL;
                end else begin
                  cmd.sol_clear = 1'b1;
                  if (c == atl_pkg::CH_SLASH) begin
                    mode_next = atl_pkg::M_SLASH;
                  end else if (st.ti_en && ((st.sol && c == atl_pkg::CH_STAR) ||
                                            c == atl_pkg::CH_SEMI)) begin
                    mode_next = atl_pkg::M_LCOM;
                  end else if (atl_pkg::is_alpha(c) || c == atl_pkg::CH_DOT ||
                               c == atl_pkg::CH_UNDER) begin
                    cmd.txt_op = atl_pkg::TXT_START;
                    mode_next  = atl_pkg::M_NAME;
                  end else if (atl_pkg::is_digit(c)) begin
                    cmd.txt_op = atl_pkg::TXT_START;
                    cmd.acc_op = atl_pkg::ACC_DIGIT;
                    mode_next  = (c == atl_pkg::CH_ZERO) ? atl_pkg::M_ZERO : atl_pkg::M_DEC;
                  end else if (c == atl_pkg::CH_QUOTE) begin
                    cmd.acc_op  = atl_pkg::ACC_ZERO;
                    cmd.cc_zero = 1'b1;
                    mode_next   = atl_pkg::M_CHR;
                  end else if (c == atl_pkg::CH_DQUOTE) begin
                    cmd.txt_op = atl_pkg::TXT_CLEAR;
                    mode_next  = atl_pkg::M_STR;
                  end else if (c == atl_pkg::CH_LT || c == atl_pkg::CH_GT ||
                               c == atl_pkg::CH_PLUS || c == atl_pkg::CH_MINUS ||
                               (c == atl_pkg::CH_BAR && st.barbar_en)) begin
                    cmd.look_load = 1'b1;
                    mode_next     = atl_pkg::M_OP;
                  end else begin
                    cmd = em(cmd, atl_pkg::KIND_SINGLE, atl_pkg::VAL_BYTE, atl_pkg::ERR_NONE);
                  end
                end
              end
            endcase
          end
        end
      end
      default: phase_next = atl_pkg::PH_WAIT;
    endcase
  end

endmodule

>>> sv/assembler_token_lexer.sv
// assembler token lexer top level: controller plus datapath
// a byte goes to the input hold register; its result is then written to the result register
// bytes: a new byte is taken only once the last one, any rescan of it and all its results are done
// a text run gives one result per character from the text buffer; its end byte may be rescanned
// stalls: the controller waits while the result register is full and out_ready is low
// reset (rst, synchronous): line 1, line start set, lexer idle, counters, flags, out_valid cleared
`timescale 1ns / 1ps
module assembler_token_lexer #(
  parameter int MAX_TEXT  = 32,
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [31:0] token_value,
  output logic        run_last,
  output logic [15:0] line_number,
  output logic [3:0]  error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_TEXT);
  localparam int CW = $clog2(MAX_TEXT + 2);

  atl_pkg::dp_cmd_t  cmd;
  atl_pkg::dp_stat_t st;
  logic [AW-1:0]     rd_addr;
  logic [CW-1:0]     run_n;

  assign cfg_ready = 1'b1;

  atl_controller #(.MAX_TEXT(MAX_TEXT), .AW(AW), .CW(CW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .run_n    (run_n),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  atl_datapath #(.MAX_TEXT(MAX_TEXT), .LINE_BITS(LINE_BITS), .AW(AW), .CW(CW)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .byte_in      (byte_in),
    .end_of_input (end_of_input),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .st           (st),
    .run_n        (run_n),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .token_kind   (token_kind),
    .token_value  (token_value),
    .run_last     (run_last),
    .line_number  (line_number),
    .error_code   (error_code)
  );

endmodule

>>> sv/atl_checker.sv
// port-level checker for the assembler token lexer, bound to the top level
`timescale 1ns / 1ps
module atl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  token_kind,
  input logic [31:0] token_value,
  input logic        run_last,
  input logic [15:0] line_number,
  input logic [3:0]  error_code
);

  a_err_only_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != atl_pkg::ERR_NONE |-> token_kind == atl_pkg::KIND_DIAG)
    else $error("error code on a non-diagnostic transaction");

  a_diag_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == atl_pkg::KIND_DIAG |->
      run_last && token_value == 32'd0 && error_code != atl_pkg::ERR_NONE)
    else $error("malformed diagnostic transaction");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != 16'd0)
    else $error("line number zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_value) && $stable(token_kind))
    else $error("result changed while stalled");

endmodule

bind assembler_token_lexer atl_checker u_atl_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .token_kind  (token_kind),
  .token_value (token_value),
  .run_last    (run_last),
  .line_number (line_number),
  .error_code  (error_code)
);

>>> sim/tb_assembler_token_lexer.sv
// self-checking testbench for the assembler token lexer with a built-in lexer predictor
`timescale 1ns / 1ps
module tb_assembler_token_lexer;

  localparam logic [7:0] REG_TI_COMMENTS = 8'd0;
  localparam logic [7:0] REG_BARBAR      = 8'd1;
  localparam logic [7:0] REG_UNUSED      = 8'd2;
  localparam int TEXT_MAX     = 32;
  localparam int STEP_MAX     = 34;
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_BYTES = 16;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic        last;
    logic [15:0] line;
    logic [3:0]  err;
  } token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] byte_in = 8'd0;
  logic end_of_input = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [7:0] cfg_index = 8'd0;
  logic [31:0] cfg_data = 32'd0;
  logic in_ready, out_valid, run_last, cfg_ready;
  logic [3:0] token_kind, error_code;
  logic [31:0] token_value;
  logic [15:0] line_number;

  assembler_token_lexer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .byte_in(byte_in), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready), .token_kind(token_kind),
    .token_value(token_value), .run_last(run_last), .line_number(line_number),
    .error_code(error_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #4 clk = ~clk;

  // lexer predictor state
  token_t expected_tokens[$];
  atl_pkg::lex_mode_t lx_mode = atl_pkg::M_IDLE;
  logic [15:0] lx_line = 16'd1;
  bit lx_sol = 1'b1;
  bit lx_eof = 1'b0;
  logic [31:0] lx_acc = 32'd0;
  logic [7:0] lx_text [TEXT_MAX];
  int lx_tcnt = 0;
  int lx_ccnt = 0;
  logic [7:0] lx_look = 8'd0;
  int step_tokens;
  bit ti_en = 1'b0;
  bit bar_en = 1'b0;

  int errors = 0;
  int hold_cycles = 0;
  bit no_gaps = 1'b0;
  int bytes_sent = 0;

  function automatic bit c_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction
  function automatic bit c_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit c_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function void push_token(logic [3:0] k, logic [31:0] v, logic l, logic [3:0] e);
    token_t t;
    if (step_tokens >= STEP_MAX) return;
    t.kind = k; t.value = v; t.last = l; t.line = lx_line; t.err = e;
    expected_tokens.push_back(t);
    step_tokens++;
  endfunction

  function void push_diag(logic [3:0] e);
    push_token(atl_pkg::KIND_DIAG, 32'd0, 1'b1, e);
  endfunction

  function void count_line();
    if (lx_line != 16'hffff) lx_line++;
  endfunction

  function void skip_space(logic [7:0] c);
    if (c == atl_pkg::CH_NL) begin
      count_line();
      lx_sol = 1'b1;
    end else lx_sol = 1'b0;
  endfunction

  function void text_push(logic [7:0] c, bit report);
    if (lx_tcnt < TEXT_MAX) begin
      lx_text[lx_tcnt] = c;
      lx_tcnt++;
    end else if (lx_tcnt == TEXT_MAX) begin
      lx_tcnt = TEXT_MAX + 1;
      if (report) push_diag(atl_pkg::ERR_TRUNC);
    end
  endfunction

  function void emit_run(logic [3:0] k);
    int n;
    n = lx_tcnt > TEXT_MAX ? TEXT_MAX : lx_tcnt;
    for (int i = 0; i < n; i++)
      push_token(k, {24'd0, lx_text[i]}, i + 1 == n, atl_pkg::ERR_NONE);
  endfunction

  function int unescape(logic [7:0] c);
    case (c)
      "n": return 10;
      "r": return 13;
      "a": return 7;
      "b": return 8;
      "f": return 12;
      "t": return 9;
      "v": return 11;
      "0": return -1;
      atl_pkg::CH_BSLASH, atl_pkg::CH_QUOTE, atl_pkg::CH_DQUOTE: return int'(c);
      default: begin
        push_diag(atl_pkg::ERR_BAD_ESC);
        return int'(atl_pkg::CH_QMARK);
      end
    endcase
  endfunction

  function void char_shift(logic [7:0] c);
    lx_acc = {lx_acc[23:0], c};
    if (lx_ccnt < 5) lx_ccnt++;
  endfunction

  function void exponent_fail();
    push_diag(atl_pkg::ERR_BAD_EXP);
    lx_tcnt = lx_acc > TEXT_MAX ? TEXT_MAX + 1 : int'(lx_acc);
    emit_run(atl_pkg::KIND_FLOAT);
  endfunction

  function void lex_idle(logic [7:0] c);
    bit sol;
    if (c_space(c)) begin
      skip_space(c);
      return;
    end
    sol = lx_sol;
    lx_sol = 1'b0;
    if (c == atl_pkg::CH_SLASH) lx_mode = atl_pkg::M_SLASH;
    else if (ti_en && ((sol && c == atl_pkg::CH_STAR) || c == atl_pkg::CH_SEMI))
      lx_mode = atl_pkg::M_LCOM;
    else if (c_alpha(c) || c == atl_pkg::CH_DOT || c == atl_pkg::CH_UNDER) begin
      lx_tcnt = 0;
      text_push(c, 1);
      lx_mode = atl_pkg::M_NAME;
    end else if (c_digit(c)) begin
      lx_tcnt = 0;
      text_push(c, 0);
      lx_acc = 32'(c - 8'h30);
      lx_mode = (c == atl_pkg::CH_ZERO) ? atl_pkg::M_ZERO : atl_pkg::M_DEC;
    end else if (c == atl_pkg::CH_QUOTE) begin
      lx_acc = 32'd0;
      lx_ccnt = 0;
      lx_mode = atl_pkg::M_CHR;
    end else if (c == atl_pkg::CH_DQUOTE) begin
      lx_tcnt = 0;
      lx_mode = atl_pkg::M_STR;
    end else if (c == atl_pkg::CH_LT || c == atl_pkg::CH_GT || c == atl_pkg::CH_PLUS ||
                 c == atl_pkg::CH_MINUS || (c == atl_pkg::CH_BAR && bar_en)) begin
      lx_look = c;
      lx_mode = atl_pkg::M_OP;
    end else push_token(atl_pkg::KIND_SINGLE, {24'd0, c}, 1'b1, atl_pkg::ERR_NONE);
  endfunction

  function logic [3:0] operator_kind(logic [7:0] c);
    case (c)
      atl_pkg::CH_LT: return atl_pkg::KIND_SHL;
      atl_pkg::CH_GT: return atl_pkg::KIND_SHR;
      atl_pkg::CH_PLUS: return atl_pkg::KIND_INC;
      atl_pkg::CH_MINUS: return atl_pkg::KIND_DEC;
      default: return atl_pkg::KIND_BARBAR;
    endcase
  endfunction

  // returns 1 when the byte is lexed again in the new mode
  function bit lex_byte(logic [7:0] c);
    int v;
    case (lx_mode)
      atl_pkg::M_LCOM: begin
        if (c == atl_pkg::CH_NL) begin
          count_line();
          lx_sol = 1'b1;
          lx_mode = atl_pkg::M_IDLE;
        end
        return 0;
      end
      atl_pkg::M_BLK: begin
        if (c == atl_pkg::CH_NL) count_line();
        else if (c == atl_pkg::CH_STAR) lx_mode = atl_pkg::M_BLKSTAR;
        return 0;
      end
      atl_pkg::M_BLKSTAR: begin
        if (c == atl_pkg::CH_SLASH) lx_mode = atl_pkg::M_IDLE;
        else if (c != atl_pkg::CH_STAR) begin
          if (c == atl_pkg::CH_NL) count_line();
          lx_mode = atl_pkg::M_BLK;
        end
        return 0;
      end
      atl_pkg::M_SLASH: begin
        if (c == atl_pkg::CH_SLASH) begin lx_mode = atl_pkg::M_LCOM; return 0; end
        if (c == atl_pkg::CH_STAR) begin lx_mode = atl_pkg::M_BLK; return 0; end
        push_token(atl_pkg::KIND_SINGLE, {24'd0, atl_pkg::CH_SLASH}, 1'b1, atl_pkg::ERR_NONE);
        lx_mode = atl_pkg::M_IDLE;
        return 1;
      end
      atl_pkg::M_OP: begin
        lx_mode = atl_pkg::M_IDLE;
        if (c == lx_look) begin
          push_token(operator_kind(c), {24'd0, c}, 1'b1, atl_pkg::ERR_NONE);
          return 0;
        end
        push_token(atl_pkg::KIND_SINGLE, {24'd0, lx_look}, 1'b1, atl_pkg::ERR_NONE);
        return 1;
      end
      atl_pkg::M_NAME, atl_pkg::M_NAMEWS: begin
        if (lx_mode == atl_pkg::M_NAME && (c_alpha(c) || c_digit(c) ||
            c == atl_pkg::CH_DOT || c == atl_pkg::CH_UNDER)) begin
          text_push(c, 1);
          return 0;
        end
        if (c_space(c)) begin
          skip_space(c);
          lx_mode = atl_pkg::M_NAMEWS;
          return 0;
        end
        lx_mode = atl_pkg::M_IDLE;
        if (c == atl_pkg::CH_COLON) begin
          emit_run(atl_pkg::KIND_LABEL);
          return 0;
        end
        emit_run(atl_pkg::KIND_NAME);
        return 1;
      end
      atl_pkg::M_ZERO: begin
        if (c == atl_pkg::CH_LX || c == atl_pkg::CH_UX) begin
          lx_acc = 32'd0;
          lx_mode = atl_pkg::M_HEX;
          return 0;
        end
        if (c == atl_pkg::CH_LB || c == atl_pkg::CH_UB) begin
          lx_acc = 32'd0;
          lx_mode = atl_pkg::M_BIN;
          return 0;
        end
        lx_mode = atl_pkg::M_DEC;
        return 1;
      end
      atl_pkg::M_HEX: begin
        if (c_digit(c)) begin lx_acc = lx_acc * 32'd16 + 32'(c - 8'h30); return 0; end
        if (c >= "a" && c <= "f") begin
          lx_acc = lx_acc * 32'd16 + 32'(c - "a") + 32'd10;
          return 0;
        end
        if (c >= "A" && c <= "F") begin
          lx_acc = lx_acc * 32'd16 + 32'(c - "A") + 32'd10;
          return 0;
        end
        push_token(atl_pkg::KIND_NUMBER, lx_acc, 1'b1, atl_pkg::ERR_NONE);
        lx_mode = atl_pkg::M_IDLE;
        return 1;
      end
      atl_pkg::M_BIN: begin
        if (c == atl_pkg::CH_ZERO || c == atl_pkg::CH_ONE) begin
          lx_acc = lx_acc * 32'd2 + 32'(c - 8'h30);
          return 0;
        end
        push_token(atl_pkg::KIND_NUMBER, lx_acc, 1'b1, atl_pkg::ERR_NONE);
        lx_mode = atl_pkg::M_IDLE;
        return 1;
      end
      atl_pkg::M_DEC: begin
        if (c_digit(c)) begin
          lx_acc = lx_acc * 32'd10 + 32'(c - 8'h30);
          text_push(c, 0);
          return 0;
        end
        if (c == atl_pkg::CH_DOT) begin
          if (lx_tcnt >= TEXT_MAX) begin
            push_diag(atl_pkg::ERR_TRUNC);
            lx_tcnt = TEXT_MAX + 1;
          end else text_push(c, 1);
          lx_mode = atl_pkg::M_FRAC;
          return 0;
        end
        push_token(atl_pkg::KIND_NUMBER, lx_acc, 1'b1, atl_pkg::ERR_NONE);
        lx_mode = atl_pkg::M_IDLE;
        return 1;
      end
      atl_pkg::M_FRAC: begin
        if (c_digit(c)) begin text_push(c, 1); return 0; end
        if (c == atl_pkg::CH_LE || c == atl_pkg::CH_UE) begin
          lx_acc = 32'(lx_tcnt);
          text_push(c, 1);
          lx_mode = atl_pkg::M_EXP0;
          return 0;
        end
        emit_run(atl_pkg::KIND_FLOAT);
        lx_mode = atl_pkg::M_IDLE;
        return 1;
      end
      atl_pkg::M_EXP0, atl_pkg::M_EXPSGN: begin
        if (lx_mode == atl_pkg::M_EXP0 && (c == atl_pkg::CH_PLUS || c == atl_pkg::CH_MINUS)) begin
          text_push(c, 1);
          lx_mode = atl_pkg::M_EXPSGN;
          return 0;
        end
        if (c_digit(c)) begin
          text_push(c, 1);
          lx_mode = atl_pkg::M_EXPDIG;
          return 0;
        end
        exponent_fail();
        lx_mode = atl_pkg::M_IDLE;
        return 1;
      end
      atl_pkg::M_EXPDIG: begin
        if (c_digit(c)) begin text_push(c, 1); return 0; end
        emit_run(atl_pkg::KIND_FLOAT);
        lx_mode = atl_pkg::M_IDLE;
        return 1;
      end
      atl_pkg::M_CHR, atl_pkg::M_STR: begin
        if (lx_mode == atl_pkg::M_CHR && c == atl_pkg::CH_QUOTE) begin
          if (lx_ccnt == 0) push_diag(atl_pkg::ERR_EMPTY_CHR);
          else if (lx_ccnt > 4) push_diag(atl_pkg::ERR_LONG_CHR);
          push_token(atl_pkg::KIND_CHAR, lx_acc, 1'b1, atl_pkg::ERR_NONE);
          lx_mode = atl_pkg::M_IDLE;
          return 0;
        end
        if (lx_mode == atl_pkg::M_STR && c == atl_pkg::CH_DQUOTE) begin
          if (lx_tcnt == 0) begin
            push_diag(atl_pkg::ERR_EMPTY_STR);
            lx_text[0] = atl_pkg::CH_QMARK;
            lx_tcnt = 1;
          end
          emit_run(atl_pkg::KIND_STRING);
          lx_mode = atl_pkg::M_IDLE;
          return 0;
        end
        if (c == atl_pkg::CH_BSLASH) begin
          lx_mode = (lx_mode == atl_pkg::M_CHR) ? atl_pkg::M_CHRESC : atl_pkg::M_STRESC;
          return 0;
        end
        if ((c < 8'h20 || c == atl_pkg::CH_DEL) && c != atl_pkg::CH_TAB) begin
          if (c == atl_pkg::CH_NL) count_line();
          push_diag(atl_pkg::ERR_CNTRL);
          return 0;
        end
        if (lx_mode == atl_pkg::M_CHR) char_shift(c);
        else text_push(c, 1);
        return 0;
      end
      atl_pkg::M_CHRESC, atl_pkg::M_STRESC: begin
        if (c == atl_pkg::CH_NL) count_line();
        v = unescape(c);
        lx_mode = (lx_mode == atl_pkg::M_CHRESC) ? atl_pkg::M_CHR : atl_pkg::M_STR;
        if (v >= 0) begin
          if (lx_mode == atl_pkg::M_CHR) char_shift(v[7:0]);
          else text_push(v[7:0], 1);
        end
        return 0;
      end
      default: begin
        lx_mode = atl_pkg::M_IDLE;
        lex_idle(c);
        return 0;
      end
    endcase
  endfunction

  function void lex_end();
    case (lx_mode)
      atl_pkg::M_BLK, atl_pkg::M_BLKSTAR: push_diag(atl_pkg::ERR_EOF_COM);
      atl_pkg::M_CHR, atl_pkg::M_CHRESC: push_diag(atl_pkg::ERR_EOF_CHR);
      atl_pkg::M_STR, atl_pkg::M_STRESC: push_diag(atl_pkg::ERR_EOF_STR);
      atl_pkg::M_SLASH:
        push_token(atl_pkg::KIND_SINGLE, {24'd0, atl_pkg::CH_SLASH}, 1'b1, atl_pkg::ERR_NONE);
      atl_pkg::M_OP:
        push_token(atl_pkg::KIND_SINGLE, {24'd0, lx_look}, 1'b1, atl_pkg::ERR_NONE);
      atl_pkg::M_NAME, atl_pkg::M_NAMEWS: emit_run(atl_pkg::KIND_NAME);
      atl_pkg::M_ZERO, atl_pkg::M_HEX, atl_pkg::M_BIN, atl_pkg::M_DEC:
        push_token(atl_pkg::KIND_NUMBER, lx_acc, 1'b1, atl_pkg::ERR_NONE);
      atl_pkg::M_FRAC, atl_pkg::M_EXPDIG: emit_run(atl_pkg::KIND_FLOAT);
      atl_pkg::M_EXP0, atl_pkg::M_EXPSGN: exponent_fail();
      default: ;
    endcase
    lx_mode = atl_pkg::M_IDLE;
    lx_eof = 1'b1;
    push_token(atl_pkg::KIND_END, 32'd0, 1'b1, atl_pkg::ERR_NONE);
  endfunction

  function void predict_tokens(logic [7:0] c, logic e);
    int guard;
    guard = 0;
    step_tokens = 0;
    if (lx_eof) push_token(atl_pkg::KIND_END, 32'd0, 1'b1, atl_pkg::ERR_NONE);
    else if (e) lex_end();
    else
      while (lex_byte(c) && guard < 4) guard++;
  endfunction

  // called at a rising edge; returns at the rising edge of acceptance
  task automatic send_byte(logic [7:0] c, logic e);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : r < 60 ? 0 : r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= c;
    end_of_input <= e;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_tokens(c, e);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_TI_COMMENTS) ti_en = data[0];
    else if (idx == REG_BARBAR) bar_en = data[0];
  endtask

  // receiver with random stalls and an optional long hold-off
  initial begin
    int r, stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (no_gaps || r < 70) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          stall = r < 95 ? $urandom_range(0, 2) : $urandom_range(9, 39);
        end
      end
    end
  end

  // result checker
  initial forever begin
    token_t exp_t;
    @(negedge clk);
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected transaction kind %0d value %h", $time, token_kind, token_value);
        errors++;
      end else begin
        exp_t = expected_tokens.pop_front();
        if (token_kind !== exp_t.kind) begin
          $display("%0t: token_kind expected %0d actual %0d", $time, exp_t.kind, token_kind);
          errors++;
        end
        if (token_value !== exp_t.value) begin
          $display("%0t: token_value expected %h actual %h", $time, exp_t.value, token_value);
          errors++;
        end
        if (run_last !== exp_t.last) begin
          $display("%0t: run_last expected %0d actual %0d", $time, exp_t.last, run_last);
          errors++;
        end
        if (line_number !== exp_t.line) begin
          $display("%0t: line_number expected %0d actual %0d", $time, exp_t.line, line_number);
          errors++;
        end
        if (error_code !== exp_t.err) begin
          $display("%0t: error_code expected %0d actual %0d", $time, exp_t.err, error_code);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
        quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("assembler_token_lexer regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_alpha();
    logic [7:0] r;
    r = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? "a" + r : "A" + r;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_print();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126));
    while (c == atl_pkg::CH_QUOTE || c == atl_pkg::CH_DQUOTE || c == atl_pkg::CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] pick_escape();
    logic [7:0] opts [12] = '{"n", "r", "a", "b", "f", "t", "v", "0", atl_pkg::CH_BSLASH,
                              atl_pkg::CH_QUOTE, atl_pkg::CH_DQUOTE, "q"};
    return opts[$urandom_range(0, 11)];
  endfunction

  task automatic send_fragment();
    logic [7:0] frag[$];
    int n, r;
    string hex_chars;
    string op_chars;
    hex_chars = "0123456789abcdefABCDEF";
    op_chars = "<>+-|";
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 12))
      0: begin
        n = (r < 5) ? $urandom_range(33, 36) : $urandom_range(1, 6);
        frag.push_back(r[0] ? atl_pkg::CH_UNDER : pick_alpha());
        repeat (n - 1)
          frag.push_back(r < 20 ? pick_digit() : r < 25 ? atl_pkg::CH_DOT : pick_alpha());
        if (r < 40) begin
          if (r < 15) frag.push_back(atl_pkg::CH_SPACE);
          frag.push_back(atl_pkg::CH_COLON);
        end
      end
      1: begin
        frag.push_back(atl_pkg::CH_ZERO);
        frag.push_back(r[0] ? atl_pkg::CH_LX : atl_pkg::CH_UX);
        repeat ($urandom_range(0, 10)) frag.push_back(hex_chars[$urandom_range(0, 21)]);
      end
      2: begin
        frag.push_back(atl_pkg::CH_ZERO);
        frag.push_back(r[0] ? atl_pkg::CH_LB : atl_pkg::CH_UB);
        repeat ($urandom_range(0, 34))
          frag.push_back($urandom_range(0, 1) ? atl_pkg::CH_ONE : atl_pkg::CH_ZERO);
      end
      3: repeat ($urandom_range(1, 12)) frag.push_back(pick_digit());
      4: begin
        repeat ($urandom_range(1, r < 5 ? 34 : 4)) frag.push_back(pick_digit());
        frag.push_back(atl_pkg::CH_DOT);
        repeat ($urandom_range(0, 4)) frag.push_back(pick_digit());
        if (r < 60) begin
          frag.push_back(r[0] ? atl_pkg::CH_LE : atl_pkg::CH_UE);
          if (r < 40) frag.push_back(r[1] ? atl_pkg::CH_PLUS : atl_pkg::CH_MINUS);
          if (r < 45) repeat ($urandom_range(1, 3)) frag.push_back(pick_digit());
        end
      end
      5: begin
        frag.push_back(atl_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) begin
            frag.push_back(atl_pkg::CH_BSLASH);
            frag.push_back(pick_escape());
          end else frag.push_back(pick_print());
        end
        frag.push_back(atl_pkg::CH_QUOTE);
      end
      6: begin
        frag.push_back(atl_pkg::CH_DQUOTE);
        repeat ($urandom_range(0, 7)) begin
          n = $urandom_range(0, 9);
          if (n == 0) begin
            frag.push_back(atl_pkg::CH_BSLASH);
            frag.push_back(pick_escape());
          end else if (n == 1) frag.push_back(r[0] ? atl_pkg::CH_TAB : 8'($urandom_range(0, 31)));
          else frag.push_back(pick_print());
        end
        frag.push_back(atl_pkg::CH_DQUOTE);
      end
      7: begin
        frag.push_back(atl_pkg::CH_SLASH);
        frag.push_back(atl_pkg::CH_SLASH);
        repeat ($urandom_range(0, 5)) frag.push_back(pick_print());
        frag.push_back(atl_pkg::CH_NL);
      end
      8: begin
        frag.push_back(atl_pkg::CH_SLASH);
        frag.push_back(atl_pkg::CH_STAR);
        repeat ($urandom_range(0, 6))
          frag.push_back(r < 30 ? atl_pkg::CH_STAR : r < 50 ? atl_pkg::CH_NL : pick_print());
        frag.push_back(atl_pkg::CH_STAR);
        frag.push_back(atl_pkg::CH_SLASH);
      end
      9: begin
        n = $urandom_range(0, 4);
        frag.push_back(op_chars[n]);
        if (r < 60) frag.push_back(op_chars[n]);
      end
      10: begin
        frag.push_back(atl_pkg::CH_NL);
        frag.push_back(r[0] ? atl_pkg::CH_STAR : atl_pkg::CH_SEMI);
        repeat ($urandom_range(0, 4)) frag.push_back(pick_print());
        frag.push_back(atl_pkg::CH_NL);
      end
      11: frag.push_back(8'($urandom_range(0, 255)));
      default:
        frag.push_back(r < 50 ? atl_pkg::CH_SPACE : r < 80 ? atl_pkg::CH_NL : atl_pkg::CH_TAB);
    endcase
    if ($urandom_range(0, 1)) frag.push_back(atl_pkg::CH_SPACE);
    foreach (frag[i]) send_byte(frag[i], 1'b0);
  endtask

  task automatic test_tokens();
    send_text("lbl : name_1.x\tloop:\n");
    send_text("0xDEADbeef 0XFFFFFFFF 0b101 0B 4294967296 0 07 ");
    send_text("1.5e+10 2.5e-x 3.0e; 4.25E7 ");
    send_text("'abcde' '' 'A' '\\q' '\\0' '\\n\\\\' ");
    send_text("\"\" \"a\\tb\" \"x\\\ny\" ");
    send_byte(atl_pkg::CH_DQUOTE, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(atl_pkg::CH_DEL, 1'b0);
    send_byte(atl_pkg::CH_DQUOTE, 1'b0);
    send_text(" // line comment\n/* block ** \n */ / x ");
  endtask

  task automatic test_operators();
    send_text("<< >> ++ -- || <> +- | # @ ");
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_long_runs();
    send_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ ");
    send_text("123456789012345678901234567890123456.5 ");
    send_text("\"0123456789abcdefghijklmnopqrstuvwxyz\" ");
  endtask

  task automatic test_line_comments();
    send_text("\n* c\n; d\nx * y ; t\n");
  endtask

  task automatic test_random(int count);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_fragment();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    no_gaps = 1'b1;
    repeat (2) send_text("stall_symbol ");
    no_gaps = 1'b0;
    wait_drained();
    send_text("after ");
  endtask

  task automatic test_end_of_input();
    send_text("\"open");
    send_byte(8'h00, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tokens();
    test_operators();
    test_long_runs();
    test_line_comments();
    write_reg(REG_TI_COMMENTS, 32'd1);
    write_reg(REG_BARBAR, 32'd1);
    write_reg(REG_UNUSED, 32'd1);
    test_operators();
    test_line_comments();
    test_random(RANDOM_BYTES / 4);
    test_backpressure();
    write_reg(REG_BARBAR, 32'd0);
    no_gaps = 1'b1;
    test_random(RANDOM_BYTES / 4);
    no_gaps = 1'b0;
    write_reg(REG_TI_COMMENTS, 32'd0);
    write_reg(REG_BARBAR, 32'hffff_fffe);
    test_random(RANDOM_BYTES / 4);
    write_reg(REG_BARBAR, 32'hffff_ffff);
    test_random(RANDOM_BYTES / 4);
    test_end_of_input();
    wait_drained();
    repeat (30) @(posedge clk);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("assembler_token_lexer regression: pass");
    end else begin
      $display("assembler_token_lexer regression: fail");
    end
    $finish;
  end

endmodule
